// ===== sv/isc_pkg.sv =====
package isc_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned TOTAL_W = 30;
   localparam logic [TOTAL_W-1:0] PRIME_MOD = 30'd1000000007;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Operands for the shared compare and modular add unit.
   typedef struct packed {
      logic [TOTAL_W-1:0] acc;
      logic [TOTAL_W-1:0] addend;
      logic [VALUE_W-1:0] stored_value;
      logic [VALUE_W-1:0] new_value;
      logic               use_compare;
      logic               enable;
   } alu_in_type;

endpackage

// ===== sv/isc_store.sv =====
module isc_store #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned IDX_W = 10
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [isc_pkg::VALUE_W-1:0]   wr_value,
   input  logic [isc_pkg::TOTAL_W-1:0]   wr_count,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [isc_pkg::VALUE_W-1:0]   rd_value,
   output logic [isc_pkg::TOTAL_W-1:0]   rd_count
);

   logic [isc_pkg::VALUE_W-1:0] value_mem [DEPTH];
   logic [isc_pkg::TOTAL_W-1:0] count_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= wr_value;
         count_mem[wr_addr] <= wr_count;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value <= value_mem[rd_addr];
         rd_count <= count_mem[rd_addr];
      end
   end

endmodule

// ===== sv/isc_alu.sv =====
module isc_alu (
   input  isc_pkg::alu_in_type           alu_in,
   output logic [isc_pkg::TOTAL_W-1:0]   result
);

   logic                        take;
   logic [isc_pkg::TOTAL_W:0]   sum;
   logic [isc_pkg::TOTAL_W:0]   reduced;

   // The addend is taken when enabled and, in compare mode, only for a
   // strictly smaller stored value.
   assign take = alu_in.enable &&
                 (!alu_in.use_compare || (alu_in.stored_value < alu_in.new_value));
   assign sum = {1'b0, alu_in.acc} + {1'b0, alu_in.addend};
   assign reduced = sum - {1'b0, isc_pkg::PRIME_MOD};

   always_comb begin
      if (!take) begin
         result = alu_in.acc;
      end else if (sum >= {1'b0, isc_pkg::PRIME_MOD}) begin
         result = reduced[isc_pkg::TOTAL_W-1:0];
      end else begin
         result = sum[isc_pkg::TOTAL_W-1:0];
      end
   end

endmodule

// ===== sv/increasing_subsequence_counter.sv =====
// Channel   Direction  Ports                                 Handshake
// req       in         req_value, req_start_req              req_valid / req_ready
// rsp       out        rsp_total, rsp_full_res               rsp_valid / rsp_ready
//
// Once a word is accepted, the sequencer reads one stored entry per cycle from the
// entry store, and each entry passes through the single compare and modular add unit.
// Reset is synchronous and active high; it empties the store and clears the total.
// The request side is ready only while the sequencer is idle. A finished result waits
// in the output register, so a stalled response side holds one word and blocks the
// next only when that word's own result is ready to be written.
module increasing_subsequence_counter #(
   parameter int unsigned MAX_ITEMS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [isc_pkg::VALUE_W-1:0]   req_value,
   input  logic                          req_start_req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [isc_pkg::TOTAL_W-1:0]   rsp_total,
   output logic                          rsp_full_res
);

   // Index width covers the store depth; the count width can also hold the depth itself.
   localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

   isc_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]            entry_count_ff, entry_count_in;
   logic [isc_pkg::TOTAL_W-1:0] running_total_ff, running_total_in;
   logic [CNT_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        pend_ff, pend_in;
   logic [isc_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [isc_pkg::TOTAL_W-1:0] cnt_ff, cnt_in;
   logic                        full_ff, full_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [isc_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                        rsp_full_ff, rsp_full_in;

   logic                        req_fire;
   logic                        rd_en;
   logic                        out_free;
   logic                        wr_en;
   logic [isc_pkg::VALUE_W-1:0] rd_value;
   logic [isc_pkg::TOTAL_W-1:0] rd_count;
   isc_pkg::alu_in_type         alu_in;
   logic [isc_pkg::TOTAL_W-1:0] alu_result;

   assign req_ready    = (state_ff == isc_pkg::ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_total    = rsp_total_ff;
   assign rsp_full_res = rsp_full_ff;

   // Entries below the count are fetched in order; the store registers the data, which returns in the next cycle.
   assign rd_en    = (state_ff == isc_pkg::ST_SCAN) && (rd_idx_ff < entry_count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_en    = (state_ff == isc_pkg::ST_DONE) && out_free && !full_ff;

   isc_store #(
      .DEPTH (MAX_ITEMS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (entry_count_ff[IDX_W-1:0]),
      .wr_value (value_ff),
      .wr_count (cnt_ff),
      .rd_en    (rd_en),
      .rd_addr  (rd_idx_ff[IDX_W-1:0]),
      .rd_value (rd_value),
      .rd_count (rd_count)
   );

   // The one arithmetic unit: during the scan it folds in smaller entries' counts,
   // at the end it adds the new count to the running total unless the store is full.
   always_comb begin
      alu_in.stored_value = rd_value;
      alu_in.new_value    = value_ff;
      if (state_ff == isc_pkg::ST_SCAN) begin
         alu_in.acc         = cnt_ff;
         alu_in.addend      = rd_count;
         alu_in.use_compare = 1'b1;
         alu_in.enable      = pend_ff;
      end else begin
         alu_in.acc         = running_total_ff;
         alu_in.addend      = cnt_ff;
         alu_in.use_compare = 1'b0;
         alu_in.enable      = !full_ff;
      end
   end

   isc_alu u_alu (
      .alu_in (alu_in),
      .result (alu_result)
   );

   always_comb begin
      state_in         = state_ff;
      entry_count_in   = entry_count_ff;
      running_total_in = running_total_ff;
      rd_idx_in        = rd_idx_ff;
      pend_in          = 1'b0;
      value_in         = value_ff;
      cnt_in           = cnt_ff;
      full_in          = full_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_total_in     = rsp_total_ff;
      rsp_full_in      = rsp_full_ff;

      case (state_ff)
         isc_pkg::ST_IDLE: begin
            if (req_fire) begin
               value_in  = req_value;
               cnt_in    = isc_pkg::TOTAL_W'(1);
               rd_idx_in = '0;
               // A new sequence clears the store before this word is looked at,
               // so a full store never blocks the first word of a new sequence.
               if (req_start_req) begin
                  entry_count_in   = '0;
                  running_total_in = '0;
                  full_in          = 1'b0;
                  state_in         = isc_pkg::ST_SCAN;
               end else if (entry_count_ff == CNT_MAX) begin
                  full_in  = 1'b1;
                  state_in = isc_pkg::ST_DONE;
               end else begin
                  full_in  = 1'b0;
                  state_in = isc_pkg::ST_SCAN;
               end
            end
         end
         isc_pkg::ST_SCAN: begin
            pend_in = rd_en;
            cnt_in  = alu_result;
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = isc_pkg::ST_DONE;
            end
         end
         isc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_total_in     = alu_result;
               rsp_full_in      = full_ff;
               running_total_in = alu_result;
               if (!full_ff) begin
                  entry_count_in = entry_count_ff + CNT_W'(1);
               end
               state_in = isc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= isc_pkg::ST_IDLE;
         entry_count_ff   <= '0;
         running_total_ff <= '0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         entry_count_ff   <= entry_count_in;
         running_total_ff <= running_total_in;
         pend_ff          <= pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      value_ff     <= value_in;
      cnt_ff       <= cnt_in;
      full_ff      <= full_in;
      rsp_total_ff <= rsp_total_in;
      rsp_full_ff  <= rsp_full_in;
   end

endmodule

// ===== bench/increasing_subsequence_counter_tb.sv =====
// Testbench for the increasing subsequence counter.
//
// Every word sent on the request channel is run through a local predictor that keeps its
// own copy of the stored values, their subsequence counts, the entry count and the
// running total. The predictor queues one expected response word per request word, and a
// checker pops the oldest expectation at every accepted response word and compares the
// total and the full flag field by field.
//
// The tests run in turn: a short directed sequence that covers the value extremes, equal
// values, unsigned ordering and restarts; a fill of the whole store followed by words
// that find it full, including a restart while full; and a long run of random sequences
// shaped so that four in ten of them are mostly increasing and therefore wrap the modulus.
//
// Both the request and the response side insert random idle cycles before each word, with
// some sequences run back to back with no idling at all.
module increasing_subsequence_counter_tb;

   localparam int unsigned VALUE_W = isc_pkg::VALUE_W;
   localparam int unsigned TOTAL_W = isc_pkg::TOTAL_W;

   localparam int unsigned MAX_ENTRIES = 1024;
   localparam logic [TOTAL_W:0] MODULUS = 31'd1000000007;
   localparam int unsigned RANDOM_WORDS = 580;
   localparam int unsigned MAX_IDLE = 19;
   // The drain limit leaves a good margin over the longest time that one word can take.
   localparam int unsigned DRAIN_LIMIT = 4 * (MAX_ENTRIES + 3 + MAX_IDLE);
   localparam int unsigned WATCHDOG_TIME = 24_000_000;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic               full_res;
   } total_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                req_start_req = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [TOTAL_W-1:0]  rsp_total;
   logic                rsp_full_res;

   // The predictor's own copy of the sequence store.
   logic [VALUE_W-1:0]  seq_values [MAX_ENTRIES];
   logic [TOTAL_W-1:0]  seq_counts [MAX_ENTRIES];
   int unsigned         seq_len = 0;
   logic [TOTAL_W-1:0]  seq_total = '0;

   total_word_type      expected_totals [$];
   int unsigned         fail_count = 0;
   bit                  idling_on = 1'b1;

   increasing_subsequence_counter #(
      .MAX_ITEMS(MAX_ENTRIES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_total(rsp_total),
      .rsp_full_res(rsp_full_res)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle cycles before the next word on either side; none at all while idling is off.
   function automatic int unsigned idle_cycles();
      if (!idling_on)
         return 0;
      return $urandom_range(0, MAX_IDLE);
   endfunction

   // Addition modulo the prime; both operands are already reduced.
   function automatic logic [TOTAL_W-1:0] mod_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= MODULUS)
         sum = sum - MODULUS;
      return sum[TOTAL_W-1:0];
   endfunction

   // Works out the response to one request word and updates the predicted store. A start
   // clears the store first, so a start that meets a full store is still taken in. The
   // comparison against stored values is strictly smaller and unsigned.
   function automatic total_word_type count_subsequences(input logic [VALUE_W-1:0] value,
                                                         input logic start);
      total_word_type     word;
      logic [TOTAL_W-1:0] count;
      if (start) begin
         seq_len = 0;
         seq_total = '0;
      end
      word.full_res = 1'b0;
      if (seq_len >= MAX_ENTRIES) begin
         word.full_res = 1'b1;
      end else begin
         count = TOTAL_W'(1);
         for (int k = 0; k < seq_len; k++) begin
            if (seq_values[k] < value)
               count = mod_add(count, seq_counts[k]);
         end
         seq_values[seq_len] = value;
         seq_counts[seq_len] = count;
         seq_len++;
         seq_total = mod_add(seq_total, count);
      end
      word.total = seq_total;
      return word;
   endfunction

   // Sends one request word. It is entered at a falling edge and returns at the falling
   // edge after the word has been taken, so valid stays high across back-to-back words.
   task automatic send_word(input logic [VALUE_W-1:0] value, input logic start);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_start_req <= start;
      expected_totals.insert(expected_totals.size(), count_subsequences(value, start));
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Response side: stalls for a random number of cycles, then stays ready until a word
   // has been taken. Ready is only lowered when a stall is actually drawn.
   initial begin
      int unsigned stall;
      while (reset) @(negedge clock);
      forever begin
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Checks every accepted response word against the oldest expectation.
   always @(posedge clock) begin
      total_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_totals.size() == 0) begin
            fail_count++;
            $error("rsp_total: word with no expectation, expected none, actual %0d",
                   rsp_total);
         end else begin
            want = expected_totals.pop_front();
            if (rsp_total !== want.total) begin
               fail_count++;
               $error("rsp_total mismatch: expected %0d, actual %0d", want.total, rsp_total);
            end
            if (rsp_full_res !== want.full_res) begin
               fail_count++;
               $error("rsp_full_res mismatch: expected %0d, actual %0d",
                      want.full_res, rsp_full_res);
            end
         end
      end
   end

   // Extremes of the value, equal values, unsigned ordering around the sign bit, restarts
   // in the middle of a sequence and back to back, and a first word without a start.
   task automatic test_directed();
      send_word(32'd7, 1'b0);
      send_word(32'd100, 1'b1);
      send_word(32'd100, 1'b0);
      send_word(32'd101, 1'b0);
      send_word(32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'd0, 1'b0);
      send_word(32'd50, 1'b0);
      send_word(32'd40, 1'b0);
      send_word(32'd30, 1'b0);
      send_word(32'd0, 1'b1);
      send_word(32'd0, 1'b1);
      send_word(32'd1, 1'b0);
      send_word(32'd2, 1'b0);
      send_word(32'd3, 1'b0);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'hAAAA_AAAA, 1'b0);
   endtask

   // Fills the whole store, then sends words that find it full, then a restart that
   // meets a full store and must be taken as the first entry of the new sequence.
   task automatic test_store_full();
      send_word($urandom, 1'b1);
      for (int n = 1; n < MAX_ENTRIES; n++)
         send_word($urandom, 1'b0);
      send_word($urandom, 1'b0);
      send_word(32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word($urandom, 1'b1);
      send_word($urandom, 1'b0);
   endtask

   // Random sequences. Four in ten are mostly increasing so counts grow past the modulus;
   // the rest use a narrow range full of equal values, the full range, or values near
   // the extremes. A few words restart in the middle, and some sequences carry on from
   // the previous one without a start.
   task automatic test_random_sequences();
      int unsigned sent;
      int unsigned length;
      int unsigned shape;
      logic [VALUE_W-1:0] value;
      logic start;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         idling_on = ($urandom_range(0, 4) != 0);
         shape = $urandom_range(0, 9);
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 25);
         start = ($urandom_range(0, 4) != 0) || (seq_len + length > 300);
         value = $urandom_range(0, 1000);
         for (int n = 0; n < length; n++) begin
            case (shape)
               0, 1, 2, 3: begin
                  if (n != 0) begin
                     if ($urandom_range(0, 7) == 0)
                        value = value - $urandom_range(0, 500);
                     else
                        value = value + $urandom_range(1, 5000);
                  end
               end
               4, 5: value = $urandom_range(0, 7);
               6, 7: value = $urandom;
               8: begin
                  case ($urandom_range(0, 5))
                     0: value = 32'd0;
                     1: value = 32'd1;
                     2: value = 32'hFFFF_FFFE;
                     3: value = 32'hFFFF_FFFF;
                     4: value = 32'h7FFF_FFFF;
                     default: value = 32'h8000_0000;
                  endcase
               end
               default: value = 32'hFFFF_FF00 | $urandom_range(0, 255);
            endcase
            send_word(value, start);
            sent++;
            start = ($urandom_range(0, 49) == 0);
         end
      end
      idling_on = 1'b1;
   endtask

   // Lets every expected word arrive, waits out the longest latency for stray words and
   // reports anything still outstanding.
   task automatic drain_responses();
      int unsigned waited;
      waited = 0;
      while (expected_totals.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (MAX_ENTRIES + 8) @(posedge clock);
      if (expected_totals.size() != 0) begin
         fail_count++;
         $error("rsp_total: expected %0d more words, actual none arrived",
                expected_totals.size());
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_store_full();
      test_random_sequences();
      req_valid <= 1'b0;
      drain_responses();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // A hung handshake ends the run as a failure.
   initial begin
      #(WATCHDOG_TIME);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
